// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BBE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("bbe checker: property failed");

// Expression must never be true outside reset.
`define BBE_ASSERT_NEVER(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("bbe checker: forbidden condition seen");

`endif

// ===== rtl/core/bbe_pkg.sv =====
// ============================================================================
// bbe_pkg
// Shared constants, codes and types of the B-spline basis evaluator.
// ============================================================================
`default_nettype none
package bbe_pkg;
    localparam int MAX_KNOTS = 16;
    localparam int MAX_ORDER = 3;

    localparam int KIDX_W  = $clog2(MAX_KNOTS);
    localparam int ORD_W   = $clog2(MAX_ORDER + 1);
    localparam int CNT_W   = $clog2(MAX_KNOTS + 1);

    localparam int VAL_W    = 32;
    localparam int BASIS_W  = 17;
    localparam int DIFF_W   = VAL_W + 1;
    localparam int PROD_W   = DIFF_W + BASIS_W + 1;
    localparam int QUOT_W   = PROD_W;
    localparam int ORDER_W  = 2;
    localparam int KCOUNT_W = 5;
    localparam int IDX_W    = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_ORDER  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_KCOUNT = 1'b1;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic [BASIS_W-1:0] ONE_Q16 = 17'h10000;

    // Per-cycle controls broadcast to every cell of the row.
    typedef struct packed {
        logic shift;
        logic init;
        logic copy;
    } t_cell_ctl;
endpackage
`default_nettype wire

// ===== rtl/core/bbe_in_if.sv =====
// ============================================================================
// bbe_in_if
// Input channel: knot writes and evaluate requests.
// ============================================================================
`default_nettype none
interface bbe_in_if import bbe_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    opcode;
    logic [KIDX_W-1:0]       knot_index;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output opcode, output knot_index, output value,
                    input ready);
    modport sink   (input valid, input opcode, input knot_index, input value,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbe_out_if.sv =====
// ============================================================================
// bbe_out_if
// Output channel: one beat per reported basis index.
// ============================================================================
`default_nettype none
interface bbe_out_if import bbe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [IDX_W-1:0]   basis_index;
    logic [BASIS_W-1:0] basis_value;
    logic               basis_valid;
    logic [BASIS_W-1:0] lower_value;
    logic               last;

    modport source (output valid, output basis_index, output basis_value,
                    output basis_valid, output lower_value, output last,
                    input ready);
    modport sink   (input valid, input basis_index, input basis_value,
                    input basis_valid, input lower_value, input last,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/bbe_cell.sv =====
// ============================================================================
// bbe_cell
// One ring cell: a knot, a working basis and a lower-order basis.
// ============================================================================
`default_nettype none
module bbe_cell import bbe_pkg::*; (
    input  wire                      i_clk,
    input  wire t_cell_ctl           i_ctl,
    input  wire                      i_knot_we,
    input  wire signed [VAL_W-1:0]   i_knot_wdata,
    input  wire signed [VAL_W-1:0]   i_x,
    input  wire signed [VAL_W-1:0]   i_nb_knot,
    input  wire [BASIS_W-1:0]        i_nb_basis,
    input  wire [BASIS_W-1:0]        i_nb_lower,
    output logic signed [VAL_W-1:0]  o_knot,
    output logic [BASIS_W-1:0]       o_basis,
    output logic [BASIS_W-1:0]       o_lower
);
    logic signed [VAL_W-1:0] r_knot;
    logic [BASIS_W-1:0]      r_basis;
    logic [BASIS_W-1:0]      r_lower;

    always_ff @(posedge i_clk) begin
        if (i_knot_we) begin
            r_knot <= i_knot_wdata;
        end else if (i_ctl.shift) begin
            r_knot <= i_nb_knot;
        end
        if (i_ctl.init) begin
            // order-0 interval indicator
            r_basis <= ((i_x >= r_knot) && (i_x < i_nb_knot)) ? ONE_Q16 : '0;
        end else if (i_ctl.shift) begin
            r_basis <= i_nb_basis;
        end
        if (i_ctl.copy) begin
            r_lower <= r_basis;
        end else if (i_ctl.shift) begin
            r_lower <= i_nb_lower;
        end
    end

    assign o_knot  = r_knot;
    assign o_basis = r_basis;
    assign o_lower = r_lower;
endmodule
`default_nettype wire

// ===== rtl/core/bbe_div.sv =====
// ============================================================================
// bbe_div
// Recursion term (a * b) / d: one multiply, then restoring division, 1 bit/cycle.
// ============================================================================
`default_nettype none
module bbe_div import bbe_pkg::*; (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_start,
    input  wire signed [DIFF_W-1:0]   i_diff,
    input  wire [BASIS_W-1:0]         i_basis,
    input  wire signed [DIFF_W-1:0]   i_den,
    output logic                      o_done,
    output logic signed [QUOT_W-1:0]  o_quot
);
    localparam int MAG_W = PROD_W - 1;
    localparam int CW    = $clog2(MAG_W + 1);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_PREP, S_DIV, S_FIN} t_state;

    t_state                   r_state;
    logic signed [DIFF_W-1:0] r_a, r_d;
    logic [BASIS_W-1:0]       r_b;
    logic signed [PROD_W-1:0] r_prod;
    logic [MAG_W-1:0]         r_num;
    logic [DIFF_W-1:0]        r_den;
    logic [DIFF_W-1:0]        r_rem;
    logic [CW-1:0]            r_cnt;
    logic                     r_neg, r_zero, r_done;
    logic signed [QUOT_W-1:0] r_quot;

    logic [DIFF_W:0]          w_rem_sh;
    logic [DIFF_W:0]          w_rem_sub;
    logic                     w_qbit;
    logic [PROD_W-1:0]        w_prod_abs;
    logic [DIFF_W-1:0]        w_den_abs;

    always_comb begin
        w_rem_sh   = {r_rem, r_num[MAG_W-1]};
        w_qbit     = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub  = w_rem_sh - {1'b0, r_den};
        w_prod_abs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);
        w_den_abs  = r_d[DIFF_W-1] ? DIFF_W'(-r_d) : DIFF_W'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_a     <= i_diff;
                        r_b     <= i_basis;
                        r_d     <= i_den;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_a * $signed({1'b0, r_b}));
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_num   <= w_prod_abs[MAG_W-1:0];
                    r_den   <= w_den_abs;
                    r_neg   <= r_prod[PROD_W-1] ^ r_d[DIFF_W-1];
                    r_zero  <= (r_d == '0);
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // quotient bits shift in behind the dividend bits
                    r_rem <= w_qbit ? w_rem_sub[DIFF_W-1:0] : w_rem_sh[DIFF_W-1:0];
                    r_num <= {r_num[MAG_W-2:0], w_qbit};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(MAG_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_zero) begin
                        r_quot <= '0;
                    end else if (r_neg) begin
                        r_quot <= -$signed({1'b0, r_num});
                    end else begin
                        r_quot <= $signed({1'b0, r_num});
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

// ===== rtl/core/bspline_basis_eval_unit.sv =====
// ============================================================================
// bspline_basis_eval_unit
// Cox-de Boor B-spline basis evaluator over a rotating ring of knot cells.
// ============================================================================
// Knot write: accepted while idle, no result beats.
// Evaluate: ring rotation at each order ord = 1..k with (n-ord-1) term pairs,
//   computed on the shared bit-serial divider; then the ring streams n-k
//   result beats, slowed by output stalls.
// Next input is taken once the output sweep is done; last beat may still wait.
// Reset (sync, active low): order 3, knot count 16, idle; cells not cleared.
`default_nettype none
module bspline_basis_eval_unit import bbe_pkg::*; (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_we,
    input  wire [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data,
    bbe_in_if.sink                i_sample,
    bbe_out_if.source             o_basis
);
    typedef enum logic [2:0] {
        S_IDLE, S_INIT, S_PASS_START, S_STEP, S_T1, S_T2, S_OUT
    } t_state;

    // configuration
    logic [ORDER_W-1:0]  r_cfg_order;
    logic [KCOUNT_W-1:0] r_cfg_count;

    // sequencer
    t_state                  r_state;
    logic [ORD_W-1:0]        r_k, r_ord;
    logic [CNT_W-1:0]        r_n;
    logic [KIDX_W-1:0]       r_t;
    logic signed [VAL_W-1:0] r_x;
    logic signed [QUOT_W-1:0] r_sum;

    // output register
    logic               r_ov;
    logic [IDX_W-1:0]   r_o_idx;
    logic [BASIS_W-1:0] r_o_val;
    logic               r_o_bv;
    logic [BASIS_W-1:0] r_o_low;
    logic               r_o_last;

    // cell row
    t_cell_ctl               w_ctl;
    logic [BASIS_W-1:0]      w_insert;
    logic signed [VAL_W-1:0] w_knot  [MAX_KNOTS];
    logic [BASIS_W-1:0]      w_basis [MAX_KNOTS];
    logic [BASIS_W-1:0]      w_lower [MAX_KNOTS];
    logic [MAX_KNOTS-1:0]    w_kwe;

    // divider hookup
    logic                     w_div_start, w_div_done;
    logic signed [DIFF_W-1:0] w_div_a, w_div_d;
    logic [BASIS_W-1:0]       w_div_b;
    logic signed [QUOT_W-1:0] w_quot;

    // effective order / count of the next evaluate
    logic [ORD_W-1:0]        w_k_eff;
    logic [CNT_W-1:0]        w_n_eff;
    logic                    w_too_few;
    logic                    w_in_acc, w_out_free;
    logic [CNT_W-1:0]        w_m, w_cnt;
    logic                    w_work;
    logic signed [VAL_W-1:0] w_k_o, w_k_o1;
    logic signed [QUOT_W:0]  w_s;
    logic [BASIS_W-1:0]      w_sat;
    logic                    w_pass_end;

    always_comb begin
        if (r_cfg_order == '0) begin
            w_k_eff = ORD_W'(1);
        end else if (int'(r_cfg_order) > MAX_ORDER) begin
            w_k_eff = ORD_W'(MAX_ORDER);
        end else begin
            w_k_eff = ORD_W'(r_cfg_order);
        end
        if (int'(r_cfg_count) > MAX_KNOTS) begin
            w_n_eff = CNT_W'(MAX_KNOTS);
        end else begin
            w_n_eff = CNT_W'(r_cfg_count);
        end
        w_too_few = (int'(w_n_eff) < int'(w_k_eff) + 2);
    end

    assign i_sample.ready = (r_state == S_IDLE);
    assign w_in_acc       = i_sample.valid && i_sample.ready;
    assign w_out_free     = !r_ov || o_basis.ready;

    // terms still to compute in this pass: t < n - ord - 1
    assign w_m    = r_n - CNT_W'(r_ord) - CNT_W'(1);
    assign w_cnt  = r_n - CNT_W'(r_k);
    assign w_work = (CNT_W'(r_t) < w_m);
    // taps: knot[t+ord] and knot[t+ord+1] sit at fixed ring positions
    assign w_k_o  = w_knot[KIDX_W'(r_ord)];
    assign w_k_o1 = w_knot[KIDX_W'(r_ord) + KIDX_W'(1)];
    assign w_pass_end = (r_t == KIDX_W'(MAX_KNOTS - 1));

    // exact sum of both terms, clamped to [0, 1.0]
    always_comb begin
        w_s = $signed({r_sum[QUOT_W-1], r_sum}) + $signed({w_quot[QUOT_W-1], w_quot});
        if (w_s[QUOT_W]) begin
            w_sat = '0;
        end else if (w_s > $signed({{(QUOT_W + 1 - BASIS_W){1'b0}}, ONE_Q16})) begin
            w_sat = ONE_Q16;
        end else begin
            w_sat = w_s[BASIS_W-1:0];
        end
    end

    // cell control and divider operands
    always_comb begin
        w_ctl       = '0;
        w_insert    = w_basis[0];
        w_div_start = 1'b0;
        w_div_a     = DIFF_W'(r_x) - DIFF_W'(w_knot[0]);
        w_div_d     = DIFF_W'(w_k_o) - DIFF_W'(w_knot[0]);
        w_div_b     = w_basis[0];
        case (r_state)
            S_INIT: w_ctl.init = 1'b1;
            S_PASS_START: w_ctl.copy = (r_ord == r_k);
            S_STEP: begin
                if (w_work) begin
                    w_div_start = 1'b1;
                end else begin
                    w_ctl.shift = 1'b1;
                end
            end
            S_T1: begin
                // second term: (knot[t+ord+1] - x) * B[t+1] / (knot[t+ord+1] - knot[t+1])
                w_div_start = w_div_done;
                w_div_a     = DIFF_W'(w_k_o1) - DIFF_W'(r_x);
                w_div_d     = DIFF_W'(w_k_o1) - DIFF_W'(w_knot[1]);
                w_div_b     = w_basis[1];
            end
            S_T2: begin
                w_ctl.shift = w_div_done;
                w_insert    = w_sat;
            end
            S_OUT: begin
                w_ctl.shift = (CNT_W'(r_t) < w_cnt) ? w_out_free : 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_KNOTS; i++) begin
            w_kwe[i] = w_in_acc && (i_sample.opcode == OP_WRITE) &&
                       (i_sample.knot_index == KIDX_W'(i));
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_KNOTS; g++) begin : g_cell
            localparam int NB = (g + 1) % MAX_KNOTS;
            bbe_cell u_cell (
                .i_clk        (i_clk),
                .i_ctl        (w_ctl),
                .i_knot_we    (w_kwe[g]),
                .i_knot_wdata (i_sample.value),
                .i_x          (r_x),
                .i_nb_knot    (w_knot[NB]),
                .i_nb_basis   ((g == MAX_KNOTS - 1) ? w_insert : w_basis[NB]),
                .i_nb_lower   (w_lower[NB]),
                .o_knot       (w_knot[g]),
                .o_basis      (w_basis[g]),
                .o_lower      (w_lower[g])
            );
        end
    endgenerate

    bbe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_diff  (w_div_a),
        .i_basis (w_div_b),
        .i_den   (w_div_d),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_order <= ORDER_W'(3);
            r_cfg_count <= KCOUNT_W'(16);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORDER:  r_cfg_order <= i_cfg_data[ORDER_W-1:0];
                CFG_KCOUNT: r_cfg_count <= i_cfg_data[KCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && o_basis.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_sample.opcode == OP_EVAL) && !w_too_few) begin
                        r_x     <= i_sample.value;
                        r_k     <= w_k_eff;
                        r_n     <= w_n_eff;
                        r_ord   <= ORD_W'(1);
                        r_state <= S_INIT;
                    end
                end
                S_INIT: r_state <= S_PASS_START;
                S_PASS_START: begin
                    r_t     <= '0;
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    if (w_work) begin
                        r_state <= S_T1;
                    end else begin
                        r_t <= r_t + 1'b1;
                        if (w_pass_end) begin
                            if (r_ord == r_k) begin
                                r_state <= S_OUT;
                            end else begin
                                r_ord   <= r_ord + 1'b1;
                                r_state <= S_PASS_START;
                            end
                        end
                    end
                end
                S_T1: begin
                    if (w_div_done) begin
                        r_sum   <= w_quot;
                        r_state <= S_T2;
                    end
                end
                S_T2: begin
                    if (w_div_done) begin
                        r_t <= r_t + 1'b1;
                        // at least one unused slot remains, so a pass never ends here
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    if (CNT_W'(r_t) < w_cnt) begin
                        if (w_out_free) begin
                            r_ov     <= 1'b1;
                            r_o_idx  <= IDX_W'(r_t);
                            r_o_bv   <= (CNT_W'(r_t) < w_cnt - CNT_W'(1));
                            r_o_val  <= (CNT_W'(r_t) < w_cnt - CNT_W'(1)) ? w_basis[0] : '0;
                            r_o_low  <= w_lower[0];
                            r_o_last <= (CNT_W'(r_t) == w_cnt - CNT_W'(1));
                            r_t      <= r_t + 1'b1;
                        end
                    end else begin
                        r_t <= r_t + 1'b1;
                        if (w_pass_end) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_basis.valid       = r_ov;
    assign o_basis.basis_index = r_o_idx;
    assign o_basis.basis_value = r_o_val;
    assign o_basis.basis_valid = r_o_bv;
    assign o_basis.lower_value = r_o_low;
    assign o_basis.last        = r_o_last;
endmodule
`default_nettype wire

// ===== rtl/core/bbe_checker.sv =====
// ============================================================================
// bbe_checker
// Port-level checks on the result channel of the basis evaluator.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"
module bbe_checker import bbe_pkg::*; (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_out_valid,
    input wire               i_out_ready,
    input wire [IDX_W-1:0]   i_index,
    input wire [BASIS_W-1:0] i_value,
    input wire               i_bvalid,
    input wire [BASIS_W-1:0] i_lower,
    input wire               i_last
);
    `BBE_ASSERT(a_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_index) && $stable(i_value) && $stable(i_lower) && $stable(i_last)))
    `BBE_ASSERT_NEVER(a_range, i_clk, i_rst_n, i_out_valid && ((i_value > ONE_Q16) || (i_lower > ONE_Q16)))
    `BBE_ASSERT(a_last_flag, i_clk, i_rst_n, i_out_valid |-> (i_bvalid != i_last))
    `BBE_ASSERT(a_zero_tail, i_clk, i_rst_n, (i_out_valid && !i_bvalid) |-> (i_value == '0))
endmodule

bind bspline_basis_eval_unit bbe_checker u_bbe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_basis.valid),
    .i_out_ready (o_basis.ready),
    .i_index     (o_basis.basis_index),
    .i_value     (o_basis.basis_value),
    .i_bvalid    (o_basis.basis_valid),
    .i_lower     (o_basis.lower_value),
    .i_last      (o_basis.last)
);
`default_nettype wire

// ===== sim/bspline_basis_eval_unit_tb.sv =====
// ============================================================================
// bspline_basis_eval_unit_tb
// Self-checking bench for the B-spline basis evaluator.
// Loads knot tables, evaluates samples under several order and knot-count
// settings, and checks every result beat against a Cox-de Boor predictor
// that runs in Q16.16 / Q1.16 fixed point. Both channels get random gaps.
// ============================================================================
`default_nettype none
module bspline_basis_eval_unit_tb;
    import bbe_pkg::*;

    // One expected result beat.
    typedef struct {
        logic [IDX_W-1:0]   idx;
        logic [BASIS_W-1:0] bval;
        logic               bvalid;
        logic [BASIS_W-1:0] lval;
        logic               last;
    } t_basis_beat;

    // Scoreboard: mirrors knot table and registers, predicts result beats.
    class t_basis_scoreboard;
        longint      knots[MAX_KNOTS];
        int          order_reg;
        int          count_reg;
        t_basis_beat pending_beats[$];
        int          errors;

        function new();
            order_reg = 3;
            count_reg = 16;
            errors    = 0;
            foreach (knots[i]) knots[i] = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_ORDER) order_reg = data & 3;
            else                  count_reg = data & 31;
        endfunction

        // Fixed-point recursion term; zero knot span gives zero.
        function longint span_term(longint a, longint d, longint b);
            if (d == 0) return 0;
            return (a * b) / d;
        endfunction

        function void note_input(logic op, logic [KIDX_W-1:0] kidx,
                                 logic signed [VAL_W-1:0] v);
            longint      x;
            longint      w[MAX_KNOTS];
            longint      lw[MAX_KNOTS];
            longint      s;
            int          k;
            int          n;
            t_basis_beat bt;
            x = v;
            if (op == OP_WRITE) begin
                knots[kidx] = x;
                return;
            end
            k = (order_reg < 1) ? 1 : (order_reg > MAX_ORDER ? MAX_ORDER : order_reg);
            n = (count_reg > MAX_KNOTS) ? MAX_KNOTS : count_reg;
            if (n - k - 1 < 1) return;      // too few knots: no beats
            foreach (w[i]) begin
                w[i]  = 0;
                lw[i] = 0;
            end
            // order-0 interval indicators
            for (int t = 0; t < n - 1; t++)
                w[t] = (x >= knots[t] && x < knots[t+1]) ? 65536 : 0;
            for (int o = 1; o <= k; o++) begin
                if (o == k) lw = w;
                for (int t = 0; t < n - o - 1; t++) begin
                    s = span_term(x - knots[t], knots[t+o] - knots[t], w[t])
                      + span_term(knots[t+o+1] - x, knots[t+o+1] - knots[t+1], w[t+1]);
                    if (s < 0) s = 0;
                    if (s > 65536) s = 65536;
                    w[t] = s;
                end
            end
            for (int t = 0; t < n - k; t++) begin
                bt.idx    = IDX_W'(t);
                bt.bvalid = (t < n - k - 1);
                bt.bval   = bt.bvalid ? w[t][BASIS_W-1:0] : '0;
                bt.lval   = lw[t][BASIS_W-1:0];
                bt.last   = (t == n - k - 1);
                pending_beats.push_back(bt);
            end
        endfunction

        function void check_beat(t_basis_beat got);
            t_basis_beat exp_b;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected beat idx=%0d", got.idx);
                return;
            end
            exp_b = pending_beats.pop_front();
            if (got.idx !== exp_b.idx || got.bval !== exp_b.bval
                || got.bvalid !== exp_b.bvalid || got.lval !== exp_b.lval
                || got.last !== exp_b.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("ERROR: beat mismatch exp idx=%0d b=%h v=%b l=%h last=%b",
                             exp_b.idx, exp_b.bval, exp_b.bvalid, exp_b.lval, exp_b.last);
                    $display("                     got idx=%0d b=%h v=%b l=%h last=%b",
                             got.idx, got.bval, got.bvalid, got.lval, got.last);
                end
            end
        endfunction
    endclass

    localparam int SETTLE_CYCLES = 5000;
    localparam int WDOG_LIMIT    = 40000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bbe_in_if  smp_if();
    bbe_out_if res_if();

    bspline_basis_eval_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp_if),
        .o_basis    (res_if)
    );

    t_basis_scoreboard sb = new();
    bit              no_gaps;      // set for stretches with no idling
    int              idle_cycles;
    logic signed [VAL_W-1:0] knot_img[MAX_KNOTS];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Mostly short gaps, a few long ones.
    function automatic int gap_len();
        int r;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: ready drops for random stretches.
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            stall_left   <= gap_len();
        end
    end

    // Beat monitors: both sides sample pre-edge values.
    always @(posedge i_clk) begin
        t_basis_beat got;
        if (i_rst_n && smp_if.valid && smp_if.ready)
            sb.note_input(smp_if.opcode, smp_if.knot_index, smp_if.value);
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got.idx    = res_if.basis_index;
            got.bval   = res_if.basis_value;
            got.bvalid = res_if.basis_valid;
            got.lval   = res_if.lower_value;
            got.last   = res_if.last;
            sb.check_beat(got);
        end
    end

    // Watchdog: cycles with no beat on either channel and no config write.
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one input beat; valid stays high if the next beat follows at once.
    task automatic send_beat(logic op, logic [KIDX_W-1:0] kidx, logic signed [VAL_W-1:0] v);
        int g;
        g = gap_len();
        if (g > 0) begin
            smp_if.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        smp_if.valid      <= 1'b1;
        smp_if.opcode     <= op;
        smp_if.knot_index <= kidx;
        smp_if.value      <= v;
        do @(posedge i_clk); while (!(smp_if.valid && smp_if.ready));
    endtask

    task automatic write_knot(int idx, logic signed [VAL_W-1:0] v);
        knot_img[idx] = v;
        send_beat(OP_WRITE, idx[KIDX_W-1:0], v);
    endtask

    task automatic eval_at(logic signed [VAL_W-1:0] v);
        send_beat(OP_EVAL, KIDX_W'($urandom), v);   // knot_index is don't-care here
    endtask

    // Drain everything, then let a beat-less eval finish before reconfig.
    task automatic drain();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_beats.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_regs(int ord, int cnt);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ORDER;
        i_cfg_data <= CFG_DATA_W'(ord);
        @(posedge i_clk);
        sb.write_reg(CFG_ORDER, CFG_DATA_W'(ord));
        i_cfg_idx  <= CFG_KCOUNT;
        i_cfg_data <= CFG_DATA_W'(cnt);
        @(posedge i_clk);
        sb.write_reg(CFG_KCOUNT, CFG_DATA_W'(cnt));
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Fresh ascending knot table with random spacing; zero steps now and then.
    task automatic load_sorted_table();
        logic signed [VAL_W-1:0] k;
        k = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        for (int i = 0; i < MAX_KNOTS; i++) begin
            write_knot(i, k);
            if ($urandom_range(0, 7) != 0)
                k = k + $urandom_range(1, 32'h0004_0000);
        end
    endtask

    // Sample mostly inside the knot span, sometimes on a knot, sometimes wild.
    function automatic logic signed [VAL_W-1:0] pick_sample();
        int j;
        int r;
        j = $urandom_range(0, MAX_KNOTS - 2);
        r = $urandom_range(0, 9);
        if (r == 0) return $urandom;
        if (r == 1) return knot_img[j];
        return knot_img[j] + $signed($urandom_range(0, 32'h0004_0000));
    endfunction

    int phase_ord[8] = '{3, 1, 2, 0, 3, 2, 1, 3};
    int phase_cnt[8] = '{16, 3, 3, 8, 31, 5, 16, 4};

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= '0;
        i_cfg_data   <= '0;
        smp_if.valid <= 1'b0;
        smp_if.opcode     <= OP_WRITE;
        smp_if.knot_index <= '0;
        smp_if.value      <= '0;
        no_gaps      = 1'b0;
        idle_cycles  = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: unit-spaced table at reset settings (order 3, 16 knots).
        for (int i = 0; i < MAX_KNOTS; i++) write_knot(i, i * 65536);
        eval_at(0);                       // on the first knot
        eval_at(32'sh0003_8000);          // mid interval
        eval_at(32'sh000F_0000);          // on the last knot
        eval_at(-1);                      // below the table
        write_knot(5, knot_img[4]);       // repeated knot: zero span
        eval_at(32'sh0004_0000);
        write_knot(0, 32'sh8000_0000);    // most negative knot
        write_knot(15, 32'sh7FFF_FFFF);   // most positive knot
        eval_at(32'sh8000_0000);
        eval_at(32'sh7FFF_FFFE);
        drain();

        // Random phases over several register settings, extremes included.
        for (int p = 0; p < 8; p++) begin
            set_regs(phase_ord[p], phase_cnt[p]);
            no_gaps = (p == 1);
            if (p == 6) begin
                // noise: unsorted random knots
                for (int i = 0; i < MAX_KNOTS; i++) write_knot(i, $urandom);
            end else begin
                load_sorted_table();
            end
            for (int e = 0; e < 8; e++) begin
                if ($urandom_range(0, 5) == 0)
                    write_knot($urandom_range(0, MAX_KNOTS - 1),
                               knot_img[$urandom_range(0, MAX_KNOTS - 1)]);
                eval_at(pick_sample());
            end
            drain();
        end

        no_gaps = 1'b0;
        if (sb.errors == 0 && sb.pending_beats.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
